// ----- hw/rtl/dri_pkg.sv -----
// Shared types and constants for the delta robot inverse kinematics unit.
// No dependencies; every other RTL file imports this package.
`timescale 1ns / 1ps
`default_nettype none

package dri_pkg;

   // Core arithmetic widths (positions are brought to 24 bits before use)
   localparam int CORE_W   = 24;          // signed Q15.8 position
   localparam int LEN_W    = 23;          // unsigned arm length
   localparam int COEF_W   = 56;          // signed e, f, g coefficients
   localparam int NORM_POS = 29;          // leading one of normalized max
   localparam int NMAG_W   = 30;          // normalized magnitude
   localparam int NSGN_W   = 31;          // normalized signed coefficient
   localparam int SQR_W    = 60;          // square of a normalized magnitude
   localparam int RAD_W    = 62;          // discriminant
   localparam int ROOT_W   = 31;          // integer square root
   localparam int REM_W    = 34;          // square root remainder
   localparam int CORD_W   = 36;          // CORDIC x / y
   localparam int ANG_W    = 28;          // CORDIC angle accumulator, Q24
   localparam int ACC_W    = 34;          // offset add before saturation
   localparam int CORDIC_STEPS = 24;
   localparam int QUEUE_DEPTH  = 4;
   localparam int CSR_DATA_W   = 32;
   localparam int CSR_IDX_W    = 3;

   localparam int SQRT3_Q16  = 113512;
   localparam int TWO_PI_Q16 = 411775;

   // Leg solver depth: 6 setup stages, one stage per root bit, two select
   // stages, one stage per CORDIC step, one output stage.
   localparam int LEG_LAT = 6 + ROOT_W + 2 + CORDIC_STEPS + 1;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_UPPER_ARM  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LOWER_ARM  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_A   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_B   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_C   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_ANGLE_OFS  = 3'd5;

   // Geometry registers, already scaled to core widths
   typedef struct packed {
      logic        [LEN_W-1:0]  upper_len;
      logic        [LEN_W-1:0]  lower_len;
      logic signed [CORE_W-1:0] off_a;
      logic signed [CORE_W-1:0] off_b;
      logic signed [CORE_W-1:0] off_c;
   } geom_type;

   // Coefficients of the three legs for one position
   typedef struct packed {
      logic signed [COEF_W-1:0] e1;
      logic signed [COEF_W-1:0] e2;
      logic signed [COEF_W-1:0] e3;
      logic signed [COEF_W-1:0] f;
      logic signed [COEF_W-1:0] g1;
      logic signed [COEF_W-1:0] g2;
      logic signed [COEF_W-1:0] g3;
   } coef_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   // atan(2^-i) in Q24 radians
   function automatic logic signed [ANG_W-1:0] atan_q24(input int i);
      logic signed [ANG_W-1:0] v;
      case (i)
         0:  v = 28'sd13176795;
         1:  v = 28'sd7778716;
         2:  v = 28'sd4110060;
         3:  v = 28'sd2086331;
         4:  v = 28'sd1047214;
         5:  v = 28'sd524117;
         6:  v = 28'sd262123;
         7:  v = 28'sd131069;
         8:  v = 28'sd65536;
         9:  v = 28'sd32768;
         10: v = 28'sd16384;
         11: v = 28'sd8192;
         12: v = 28'sd4096;
         13: v = 28'sd2048;
         14: v = 28'sd1024;
         15: v = 28'sd512;
         16: v = 28'sd256;
         17: v = 28'sd128;
         18: v = 28'sd64;
         19: v = 28'sd32;
         20: v = 28'sd16;
         21: v = 28'sd8;
         22: v = 28'sd4;
         23: v = 28'sd2;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/dri_front.sv -----
// Front pipeline: accepts positions and forms e, f, g for all three legs.
// Depends on dri_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dri_front #(
   parameter int POS_WIDTH = 24
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic signed [POS_WIDTH-1:0] req_pos_x,
   input  wire logic signed [POS_WIDTH-1:0] req_pos_y,
   input  wire logic signed [POS_WIDTH-1:0] req_pos_z,
   input  wire dri_pkg::geom_type           geom,
   input  wire dri_pkg::q_status_type       q_stat,
   output logic                             push,
   output dri_pkg::coef_type                coef
);
   import dri_pkg::*;

   localparam int PRE_SHIFT = (POS_WIDTH > CORE_W) ? POS_WIDTH - CORE_W : 0;
   localparam int SUM_W = CORE_W + 1;
   localparam int SQ_W  = 2 * SUM_W;
   localparam int HW    = 44;
   localparam int H_W   = HW - 16;
   localparam logic signed [17:0] SQRT3_S = 18'sd113512;
   localparam logic signed [HW-1:0] HALF = 44'sd32768;

   logic [3:0] vld_ff;
   logic advance;

   // stage 1
   logic signed [CORE_W-1:0] x_ff, z_ff, ls_ff, ms_ff;
   logic signed [SUM_W-1:0]  ya_ff, xpb_ff, xmb_ff, yc_ff;
   logic signed [CORE_W-1:0] x_in, y_in, z_in;
   // stage 2
   logic signed [SQ_W-1:0] x2_ff, ya2_ff, xpb2_ff, xmb2_ff, yc2_ff, z2_ff, l2_ff, m2_ff;
   logic signed [SQ_W-1:0] zl_ff, lya_ff;
   logic signed [HW-1:0]   p2_ff, p3_ff;
   logic signed [CORE_W-1:0] ls2_ff;
   logic signed [SUM_W-1:0]  yc2c_ff;
   // stage 3
   logic signed [H_W-1:0]    h2_ff, h3_ff;
   logic signed [COEF_W-1:0] e1_ff, f_ff, s1_ff, s2_ff, s3_ff, cm_ff;
   logic signed [CORE_W-1:0] ls3_ff;
   logic signed [HW-1:0]     h2_sum, h3_sum;
   // stage 4
   coef_type coef_ff;

   assign advance   = !vld_ff[3] || !q_stat.full;
   assign req_stall = !advance;
   assign push      = vld_ff[3] && !q_stat.full;
   assign coef      = coef_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[2:0], req_valid};
      end
   end

   always_comb begin
      x_in = CORE_W'(req_pos_x >>> PRE_SHIFT);
      y_in = CORE_W'(req_pos_y >>> PRE_SHIFT);
      z_in = CORE_W'(req_pos_z >>> PRE_SHIFT);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         x_ff   <= x_in;
         z_ff   <= z_in;
         ls_ff  <= $signed({1'b0, geom.upper_len});
         ms_ff  <= $signed({1'b0, geom.lower_len});
         ya_ff  <= SUM_W'(y_in) + SUM_W'(geom.off_a);
         xpb_ff <= SUM_W'(x_in) + SUM_W'(geom.off_b);
         xmb_ff <= SUM_W'(x_in) - SUM_W'(geom.off_b);
         yc_ff  <= SUM_W'(y_in) + SUM_W'(geom.off_c);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         x2_ff   <= x_ff * x_ff;
         ya2_ff  <= ya_ff * ya_ff;
         xpb2_ff <= xpb_ff * xpb_ff;
         xmb2_ff <= xmb_ff * xmb_ff;
         yc2_ff  <= yc_ff * yc_ff;
         z2_ff   <= z_ff * z_ff;
         l2_ff   <= ls_ff * ls_ff;
         m2_ff   <= ms_ff * ms_ff;
         zl_ff   <= z_ff * ls_ff;
         lya_ff  <= ls_ff * ya_ff;
         p2_ff   <= SQRT3_S * xpb_ff;
         p3_ff   <= SQRT3_S * xmb_ff;
         ls2_ff  <= ls_ff;
         yc2c_ff <= yc_ff;
      end
   end

   // round(sqrt3*(x+-b) +- (y+c)) with add-half-then-floor
   always_comb begin
      h2_sum = p2_ff + (HW'(yc2c_ff) <<< 16) + HALF;
      h3_sum = p3_ff - (HW'(yc2c_ff) <<< 16) + HALF;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         h2_ff  <= h2_sum[HW-1:16];
         h3_ff  <= h3_sum[HW-1:16];
         e1_ff  <= COEF_W'(lya_ff) <<< 1;
         f_ff   <= COEF_W'(zl_ff) <<< 1;
         s1_ff  <= COEF_W'(x2_ff) + COEF_W'(ya2_ff);
         s2_ff  <= COEF_W'(xpb2_ff) + COEF_W'(yc2_ff);
         s3_ff  <= COEF_W'(xmb2_ff) + COEF_W'(yc2_ff);
         cm_ff  <= COEF_W'(z2_ff) + COEF_W'(l2_ff) - COEF_W'(m2_ff);
         ls3_ff <= ls2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         coef_ff.e1 <= e1_ff;
         coef_ff.e2 <= -(ls3_ff * h2_ff);
         coef_ff.e3 <= ls3_ff * h3_ff;
         coef_ff.f  <= f_ff;
         coef_ff.g1 <= s1_ff + cm_ff;
         coef_ff.g2 <= s2_ff + cm_ff;
         coef_ff.g3 <= s3_ff + cm_ff;
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/dri_queue.sv -----
// Short coefficient queue between the front and back pipelines.
// Depends on dri_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dri_queue (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire dri_pkg::coef_type     wr_data,
   input  wire logic                  pop,
   output dri_pkg::coef_type          rd_data,
   output dri_pkg::q_status_type      q_stat
);
   import dri_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = PTR_W + 1;

   coef_type          mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]  count_ff;

   assign rd_data      = mem_ff[rd_ptr_ff];
   assign q_stat.full  = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign q_stat.empty = (count_ff == '0);

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         case ({push, pop})
            2'b10:   count_ff <= count_ff + 1'b1;
            2'b01:   count_ff <= count_ff - 1'b1;
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/dri_leg.sv -----
// One leg solver lane: normalize, discriminant, square root, root select,
// CORDIC half-angle arctangent, offset and saturation. Depends on dri_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dri_leg #(
   parameter int ANGLE_WIDTH = 20
) (
   input  wire logic                          clock,
   input  wire logic                          advance,
   input  wire logic signed [dri_pkg::COEF_W-1:0] e,
   input  wire logic signed [dri_pkg::COEF_W-1:0] f,
   input  wire logic signed [dri_pkg::COEF_W-1:0] g,
   input  wire logic signed [ANGLE_WIDTH-1:0] angle_offset,
   output logic signed [ANGLE_WIDTH-1:0]      theta,
   output logic                               err
);
   import dri_pkg::*;

   localparam int NGRP = COEF_W / 8;
   localparam int P_W  = 6;
   localparam logic signed [ACC_W-1:0] SAT_HI =
      $signed((ACC_W'(1) << (ANGLE_WIDTH - 1)) - ACC_W'(1));
   localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);
   localparam logic signed [ACC_W-1:0] TWO_PI = ACC_W'(TWO_PI_Q16);
   localparam logic signed [ACC_W-1:0] ERR_THETA = (TWO_PI > SAT_HI) ? SAT_HI : TWO_PI;

   function automatic logic [2:0] top_bit8(input logic [7:0] v);
      logic [2:0] p;
      p = '0;
      for (int i = 0; i < 8; i++) begin
         if (v[i]) p = 3'(i);
      end
      return p;
   endfunction

   function automatic logic [NMAG_W-1:0] norm_mag(input logic [COEF_W-1:0] m,
                                                  input logic [P_W-1:0] p);
      logic [COEF_W-1:0] t;
      if (p >= P_W'(NORM_POS)) t = m >> (p - P_W'(NORM_POS));
      else                     t = m << (P_W'(NORM_POS) - p);
      return t[NMAG_W-1:0];
   endfunction

   // stage 1: magnitudes
   logic [COEF_W-1:0] me1_ff, mf1_ff, mg1_ff;
   logic [2:0]        sg1_ff;
   // stage 2: leading one by byte
   logic [COEF_W-1:0] me2_ff, mf2_ff, mg2_ff;
   logic [2:0]        sg2_ff;
   logic [NGRP-1:0]   gnz_ff;
   logic [2:0]        gpos_ff [NGRP];
   logic [COEF_W-1:0] om;
   // stage 3: shift position
   logic [COEF_W-1:0] me3_ff, mf3_ff, mg3_ff;
   logic [2:0]        sg3_ff;
   logic [P_W-1:0]    p3_ff;
   logic              zero3_ff;
   logic [P_W-1:0]    p_sel;
   // stage 4: normalized magnitudes
   logic [NMAG_W-1:0] ne_ff, nf_ff, ng_ff;
   logic [2:0]        sg4_ff;
   logic              err4_ff;
   // stage 5: squares
   logic [SQR_W-1:0]         qe_ff, qf_ff, qg_ff;
   logic signed [NSGN_W-1:0] se5_ff, sf5_ff, sg5_ff;
   logic                     err5_ff;
   // stage 6 and square root chain
   logic [RAD_W-1:0]         sum_d, rad_in;
   logic [RAD_W-1:0]         rad_ff  [ROOT_W+1];
   logic [REM_W-1:0]         rem_ff  [ROOT_W+1];
   logic [ROOT_W-1:0]        root_ff [ROOT_W+1];
   logic signed [NSGN_W-1:0] qe_s_ff [ROOT_W+1];
   logic signed [NSGN_W-1:0] qf_s_ff [ROOT_W+1];
   logic signed [NSGN_W-1:0] qg_s_ff [ROOT_W+1];
   logic                     qerr_ff [ROOT_W+1];
   // root select
   logic signed [32:0] den_ff, n0_ff, n1_ff;
   logic               errp_ff;
   logic [32:0]        mden, mn0, mn1;
   logic signed [32:0] num_sel, y_sel;
   logic               c0, c1;
   // CORDIC chain
   logic signed [CORD_W-1:0] cx_ff [CORDIC_STEPS+1];
   logic signed [CORD_W-1:0] cy_ff [CORDIC_STEPS+1];
   logic signed [ANG_W-1:0]  cz_ff [CORDIC_STEPS+1];
   logic                     cok_ff [CORDIC_STEPS+1];
   // output
   logic signed [ANG_W:0]    t2;
   logic signed [ACC_W-1:0]  sum_a, sat_a;
   logic signed [ANGLE_WIDTH-1:0] theta_ff;
   logic                     err_ff;

   assign theta = theta_ff;
   assign err   = err_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         me1_ff <= e[COEF_W-1] ? COEF_W'(-e) : COEF_W'(e);
         mf1_ff <= f[COEF_W-1] ? COEF_W'(-f) : COEF_W'(f);
         mg1_ff <= g[COEF_W-1] ? COEF_W'(-g) : COEF_W'(g);
         sg1_ff <= {g[COEF_W-1], f[COEF_W-1], e[COEF_W-1]};
      end
   end

   // The leading one of the OR equals that of the largest magnitude.
   assign om = me1_ff | mf1_ff | mg1_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         me2_ff <= me1_ff;
         mf2_ff <= mf1_ff;
         mg2_ff <= mg1_ff;
         sg2_ff <= sg1_ff;
         for (int k = 0; k < NGRP; k++) begin
            gnz_ff[k]  <= |om[k*8 +: 8];
            gpos_ff[k] <= top_bit8(om[k*8 +: 8]);
         end
      end
   end

   always_comb begin
      p_sel = '0;
      for (int k = 0; k < NGRP; k++) begin
         if (gnz_ff[k]) p_sel = {3'(k), gpos_ff[k]};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         me3_ff   <= me2_ff;
         mf3_ff   <= mf2_ff;
         mg3_ff   <= mg2_ff;
         sg3_ff   <= sg2_ff;
         p3_ff    <= p_sel;
         zero3_ff <= ~|gnz_ff;
      end
   end

   // right shifts truncate magnitudes toward zero, left shifts are exact
   always_ff @(posedge clock) begin
      if (advance) begin
         ne_ff   <= norm_mag(me3_ff, p3_ff);
         nf_ff   <= norm_mag(mf3_ff, p3_ff);
         ng_ff   <= norm_mag(mg3_ff, p3_ff);
         sg4_ff  <= sg3_ff;
         err4_ff <= zero3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         qe_ff   <= ne_ff * ne_ff;
         qf_ff   <= nf_ff * nf_ff;
         qg_ff   <= ng_ff * ng_ff;
         se5_ff  <= sg4_ff[0] ? -$signed({1'b0, ne_ff}) : $signed({1'b0, ne_ff});
         sf5_ff  <= sg4_ff[1] ? -$signed({1'b0, nf_ff}) : $signed({1'b0, nf_ff});
         sg5_ff  <= sg4_ff[2] ? -$signed({1'b0, ng_ff}) : $signed({1'b0, ng_ff});
         err5_ff <= err4_ff;
      end
   end

   always_comb begin
      sum_d  = RAD_W'(qe_ff) + RAD_W'(qf_ff);
      rad_in = sum_d - RAD_W'(qg_ff);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rad_ff[0]  <= rad_in;
         rem_ff[0]  <= '0;
         root_ff[0] <= '0;
         qe_s_ff[0] <= se5_ff;
         qf_s_ff[0] <= sf5_ff;
         qg_s_ff[0] <= sg5_ff;
         qerr_ff[0] <= err5_ff || (sum_d < RAD_W'(qg_ff));
      end
   end

   // digit-by-digit square root, one root bit per stage
   for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
      logic [REM_W-1:0] r2, trial;
      assign r2    = {rem_ff[k][REM_W-3:0], rad_ff[k][RAD_W-1-2*k -: 2]};
      assign trial = REM_W'({root_ff[k], 2'b01});
      always_ff @(posedge clock) begin
         if (advance) begin
            if (r2 >= trial) begin
               rem_ff[k+1]  <= r2 - trial;
               root_ff[k+1] <= {root_ff[k][ROOT_W-2:0], 1'b1};
            end else begin
               rem_ff[k+1]  <= r2;
               root_ff[k+1] <= {root_ff[k][ROOT_W-2:0], 1'b0};
            end
            rad_ff[k+1]  <= rad_ff[k];
            qe_s_ff[k+1] <= qe_s_ff[k];
            qf_s_ff[k+1] <= qf_s_ff[k];
            qg_s_ff[k+1] <= qg_s_ff[k];
            qerr_ff[k+1] <= qerr_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         den_ff  <= 33'(qg_s_ff[ROOT_W]) - 33'(qe_s_ff[ROOT_W]);
         n0_ff   <= -33'(qf_s_ff[ROOT_W]) - $signed({2'b00, root_ff[ROOT_W]});
         n1_ff   <= -33'(qf_s_ff[ROOT_W]) + $signed({2'b00, root_ff[ROOT_W]});
         errp_ff <= qerr_ff[ROOT_W];
      end
   end

   // minus root first; |num| < |den| means the angle lies inside +-pi/2
   always_comb begin
      mden    = den_ff[32] ? 33'(-den_ff) : 33'(den_ff);
      mn0     = n0_ff[32] ? 33'(-n0_ff) : 33'(n0_ff);
      mn1     = n1_ff[32] ? 33'(-n1_ff) : 33'(n1_ff);
      c0      = mn0 < mden;
      c1      = mn1 < mden;
      num_sel = c0 ? n0_ff : n1_ff;
      y_sel   = den_ff[32] ? -num_sel : num_sel;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         cx_ff[0]  <= $signed(CORD_W'(mden));
         cy_ff[0]  <= CORD_W'(y_sel);
         cz_ff[0]  <= '0;
         cok_ff[0] <= !errp_ff && (c0 || c1);
      end
   end

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
      localparam logic signed [ANG_W-1:0] ATAN_I = atan_q24(i);
      always_ff @(posedge clock) begin
         if (advance) begin
            if (!cy_ff[i][CORD_W-1]) begin
               cx_ff[i+1] <= cx_ff[i] + (cy_ff[i] >>> i);
               cy_ff[i+1] <= cy_ff[i] - (cx_ff[i] >>> i);
               cz_ff[i+1] <= cz_ff[i] + ATAN_I;
            end else begin
               cx_ff[i+1] <= cx_ff[i] - (cy_ff[i] >>> i);
               cy_ff[i+1] <= cy_ff[i] + (cx_ff[i] >>> i);
               cz_ff[i+1] <= cz_ff[i] - ATAN_I;
            end
            cok_ff[i+1] <= cok_ff[i];
         end
      end
   end

   // double the angle, round Q24 to Q16, add offset, saturate
   always_comb begin
      t2    = ((ANG_W+1)'(cz_ff[CORDIC_STEPS]) <<< 1) + (ANG_W+1)'(128);
      sum_a = ACC_W'(t2 >>> 8) + ACC_W'(angle_offset);
      if (!cok_ff[CORDIC_STEPS]) sat_a = ERR_THETA;
      else if (sum_a > SAT_HI)   sat_a = SAT_HI;
      else if (sum_a < SAT_LO)   sat_a = SAT_LO;
      else                       sat_a = sum_a;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         theta_ff <= sat_a[ANGLE_WIDTH-1:0];
         err_ff   <= !cok_ff[CORDIC_STEPS];
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/dri_back.sv -----
// Back pipeline: pops coefficients, runs three leg solver lanes in lockstep
// and holds the result transaction. Depends on dri_pkg and dri_leg.
`timescale 1ns / 1ps
`default_nettype none

module dri_back #(
   parameter int ANGLE_WIDTH = 20
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire dri_pkg::q_status_type         q_stat,
   input  wire dri_pkg::coef_type             head,
   output logic                               pop,
   input  wire logic signed [ANGLE_WIDTH-1:0] angle_offset,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic signed [ANGLE_WIDTH-1:0]      theta1,
   output logic signed [ANGLE_WIDTH-1:0]      theta2,
   output logic signed [ANGLE_WIDTH-1:0]      theta3,
   output logic                               err1,
   output logic                               err2,
   output logic                               err3
);
   import dri_pkg::*;

   logic [LEG_LAT-1:0] vld_ff;
   logic advance;

   // last lane stage doubles as the output register
   assign advance   = !vld_ff[LEG_LAT-1] || !rsp_stall;
   assign pop       = advance && !q_stat.empty;
   assign rsp_valid = vld_ff[LEG_LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[LEG_LAT-2:0], pop};
      end
   end

   dri_leg #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_leg1 (
      .clock(clock), .advance(advance), .e(head.e1), .f(head.f), .g(head.g1),
      .angle_offset(angle_offset), .theta(theta1), .err(err1)
   );

   dri_leg #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_leg2 (
      .clock(clock), .advance(advance), .e(head.e2), .f(head.f), .g(head.g2),
      .angle_offset(angle_offset), .theta(theta2), .err(err2)
   );

   dri_leg #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_leg3 (
      .clock(clock), .advance(advance), .e(head.e3), .f(head.f), .g(head.g3),
      .angle_offset(angle_offset), .theta(theta3), .err(err3)
   );

endmodule

`default_nettype wire

// ----- hw/rtl/delta_robot_inverse_kinematics_unit.sv -----
// Top level of the delta robot inverse kinematics unit: register file,
// front pipeline, coefficient queue, back pipeline. Depends on dri_pkg,
// dri_front, dri_queue and dri_back.
//
//   channel  direction  handshake           payload
//   req_     in         valid / stall       pos_x, pos_y, pos_z (Q15.8)
//   rsp_     out        valid / stall       theta_leg1..3 (Q3.16), err_leg1..3
//   csr_     in         valid / ready       index, wdata
//
// Throughput is one transaction per cycle while rsp_stall is low. The path
// runs through 4 front stages, the queue and 64 stages per leg lane (31 of
// them one square root bit each, 24 of them one CORDIC step each).
// Synchronous reset clears the pipeline valids, the queue and the registers.
// A stall on rsp_ freezes the back pipeline; the 4-entry queue absorbs the
// front until it fills, then req_stall rises. csr_ready is always high.
`timescale 1ns / 1ps
`default_nettype none

module delta_robot_inverse_kinematics_unit #(
   parameter int POS_WIDTH   = 24,
   parameter int ANGLE_WIDTH = 20
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic signed [POS_WIDTH-1:0]          req_pos_x,
   input  wire logic signed [POS_WIDTH-1:0]          req_pos_y,
   input  wire logic signed [POS_WIDTH-1:0]          req_pos_z,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic signed [ANGLE_WIDTH-1:0]             rsp_theta_leg1,
   output logic signed [ANGLE_WIDTH-1:0]             rsp_theta_leg2,
   output logic signed [ANGLE_WIDTH-1:0]             rsp_theta_leg3,
   output logic                                      rsp_err_leg1,
   output logic                                      rsp_err_leg2,
   output logic                                      rsp_err_leg3,
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [dri_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire logic [dri_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import dri_pkg::*;

   // wide positions are floored to 24 bits; the equations are scale invariant
   localparam int PRE_SHIFT = (POS_WIDTH > CORE_W) ? POS_WIDTH - CORE_W : 0;

   logic        [POS_WIDTH-2:0]   upper_ff, lower_ff;
   logic signed [POS_WIDTH-1:0]   off_a_ff, off_b_ff, off_c_ff;
   logic signed [ANGLE_WIDTH-1:0] ang_ofs_ff;

   geom_type     geom;
   coef_type     front_coef, head;
   q_status_type q_stat;
   logic         push, pop;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         upper_ff   <= '0;
         lower_ff   <= '0;
         off_a_ff   <= '0;
         off_b_ff   <= '0;
         off_c_ff   <= '0;
         ang_ofs_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_UPPER_ARM: upper_ff   <= csr_wdata[POS_WIDTH-2:0];
            CSR_LOWER_ARM: lower_ff   <= csr_wdata[POS_WIDTH-2:0];
            CSR_OFFSET_A:  off_a_ff   <= csr_wdata[POS_WIDTH-1:0];
            CSR_OFFSET_B:  off_b_ff   <= csr_wdata[POS_WIDTH-1:0];
            CSR_OFFSET_C:  off_c_ff   <= csr_wdata[POS_WIDTH-1:0];
            CSR_ANGLE_OFS: ang_ofs_ff <= csr_wdata[ANGLE_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      geom.upper_len = LEN_W'(upper_ff >> PRE_SHIFT);
      geom.lower_len = LEN_W'(lower_ff >> PRE_SHIFT);
      geom.off_a     = CORE_W'(off_a_ff >>> PRE_SHIFT);
      geom.off_b     = CORE_W'(off_b_ff >>> PRE_SHIFT);
      geom.off_c     = CORE_W'(off_c_ff >>> PRE_SHIFT);
   end

   dri_front #(.POS_WIDTH(POS_WIDTH)) u_front (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_pos_x(req_pos_x), .req_pos_y(req_pos_y), .req_pos_z(req_pos_z),
      .geom(geom), .q_stat(q_stat), .push(push), .coef(front_coef)
   );

   dri_queue u_queue (
      .clock(clock), .reset(reset),
      .push(push), .wr_data(front_coef),
      .pop(pop), .rd_data(head), .q_stat(q_stat)
   );

   dri_back #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_back (
      .clock(clock), .reset(reset),
      .q_stat(q_stat), .head(head), .pop(pop), .angle_offset(ang_ofs_ff),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .theta1(rsp_theta_leg1), .theta2(rsp_theta_leg2), .theta3(rsp_theta_leg3),
      .err1(rsp_err_leg1), .err2(rsp_err_leg2), .err3(rsp_err_leg3)
   );

endmodule

`default_nettype wire
